>>> src/segment_aabb_slab_test_core_defines.svh
// Assertion macros for the segment/box slab test core.
// Used by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef SEGMENT_AABB_SLAB_TEST_CORE_DEFINES_SVH
`define SEGMENT_AABB_SLAB_TEST_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SAST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SAST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/sast_pkg.sv
// Shared constants and types for the segment/box slab test core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sast_pkg;

  localparam int unsigned CoordWidthDefault = 16;
  localparam int unsigned NumAxes           = 3;
  localparam int unsigned NumRegs           = 6;
  localparam int unsigned CfgIdxWidth       = 3;

  // Box after reset: every min +100.0 and every max -100.0 (empty).
  localparam int BoxMinReset = 25600;
  localparam int BoxMaxReset = -25600;

  localparam logic [CfgIdxWidth-1:0] REG_MIN_X = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_X = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_MIN_Y = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_Y = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_MIN_Z = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_Z = 3'd5;

  // Per-axis status after the difference stage.
  typedef struct packed {
    logic par;     // segment parallel to this slab
    logic par_ok;  // start coordinate inside the slab, bounds included
  } axis_flags_t;

endpackage

`default_nettype wire

>>> src/sast_axis.sv
// Difference stage for one axis: direction length and entry/exit numerators.
// Depends on sast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sast_axis #(
  parameter int unsigned COORD_WIDTH = sast_pkg::CoordWidthDefault
) (
  input  wire                            clk_i,
  input  wire                            en_i,
  input  wire  signed [COORD_WIDTH-1:0]  s_i,
  input  wire  signed [COORD_WIDTH-1:0]  e_i,
  input  wire  signed [COORD_WIDTH-1:0]  bmin_i,
  input  wire  signed [COORD_WIDTH-1:0]  bmax_i,
  output logic signed [COORD_WIDTH:0]    d_o,
  output logic signed [COORD_WIDTH:0]    ent_o,
  output logic signed [COORD_WIDTH:0]    ext_o,
  output sast_pkg::axis_flags_t          flags_o
);
  import sast_pkg::*;

  logic signed [COORD_WIDTH:0] s_x, e_x, mn_x, mx_x;
  logic signed [COORD_WIDTH:0] d_d, ent_d, ext_d;
  logic                        fwd;
  axis_flags_t                 flags_d;

  always_comb begin
    s_x  = {s_i[COORD_WIDTH-1], s_i};
    e_x  = {e_i[COORD_WIDTH-1], e_i};
    mn_x = {bmin_i[COORD_WIDTH-1], bmin_i};
    mx_x = {bmax_i[COORD_WIDTH-1], bmax_i};
    fwd  = (e_i > s_i);
    if (fwd) begin
      d_d   = e_x - s_x;
      ent_d = mn_x - s_x;
      ext_d = mx_x - s_x;
    end else begin
      d_d   = s_x - e_x;
      ent_d = s_x - mx_x;
      ext_d = s_x - mn_x;
    end
    flags_d.par    = (e_i == s_i);
    flags_d.par_ok = (s_i >= bmin_i) && (s_i <= bmax_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o     <= d_d;
      ent_o   <= ent_d;
      ext_o   <= ext_d;
      flags_o <= flags_d;
    end
  end

endmodule

`default_nettype wire

>>> src/sast_cross.sv
// Cross-multiply and compare stages: every entry fraction against every exit fraction.
// Depends on sast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sast_cross #(
  parameter int unsigned COORD_WIDTH = sast_pkg::CoordWidthDefault
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire  signed [COORD_WIDTH:0]  d_i     [sast_pkg::NumAxes],
  input  wire  signed [COORD_WIDTH:0]  ent_i   [sast_pkg::NumAxes],
  input  wire  signed [COORD_WIDTH:0]  ext_i   [sast_pkg::NumAxes],
  input  sast_pkg::axis_flags_t        flags_i [sast_pkg::NumAxes],
  output logic                         hit_o
);
  import sast_pkg::*;

  localparam int unsigned ProdWidth = 2 * (COORD_WIDTH + 1);
  localparam int unsigned NumPairs  = NumAxes * (NumAxes - 1);

  logic signed [ProdWidth-1:0] lhs_q [NumPairs];
  logic signed [ProdWidth-1:0] rhs_q [NumPairs];
  logic        [NumPairs-1:0]  skip_q;
  logic        [NumAxes-1:0]   self_ok_q;
  logic        [NumPairs-1:0]  pair_ok;

  // Entry of axis a must not pass exit of axis b: ent_a * d_b <= ext_b * d_a.
  for (genvar a = 0; a < NumAxes; a++) begin : g_a
    for (genvar b = 0; b < NumAxes; b++) begin : g_b
      if (a != b) begin : g_pair
        localparam int unsigned K = a * (NumAxes - 1) + ((b > a) ? b - 1 : b);
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            lhs_q[K]  <= ent_i[a] * d_i[b];
            rhs_q[K]  <= ext_i[b] * d_i[a];
            skip_q[K] <= flags_i[a].par | flags_i[b].par;
          end
        end
        assign pair_ok[K] = skip_q[K] | (lhs_q[K] <= rhs_q[K]);
      end
    end
  end

  // Per axis: parallel slabs test the point, others clip against [0,1] and themselves.
  for (genvar a = 0; a < NumAxes; a++) begin : g_self
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        self_ok_q[a] <= flags_i[a].par ? flags_i[a].par_ok
                      : ((ent_i[a] <= ext_i[a]) && (ent_i[a] <= d_i[a]) &&
                         !ext_i[a][COORD_WIDTH]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= (&self_ok_q) & (&pair_ok);
    end
  end

endmodule

`default_nettype wire

>>> src/segment_aabb_slab_test_core.sv
// Segment versus axis-aligned box test (slab method), top level.
// Takes one segment per cycle unless the result register is full and stalled.
// Stages: axis differences, cross products (one 17x17 multiplier per term), compare/reduce.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (async, active low) clears valid bits and loads the empty box (min +100, max -100).
// Depends on sast_pkg, sast_axis, sast_cross and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_aabb_slab_test_core_defines.svh"

module segment_aabb_slab_test_core #(
  parameter int unsigned COORD_WIDTH = sast_pkg::CoordWidthDefault
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Segment in. tdata from bit 0: start_x, start_y, start_z, end_x, end_y, end_z
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // Result out. tdata from bit 0: hit, then zero fill
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [7:0]                           m_axis_tdata,
  // Box register writes
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [sast_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire  [COORD_WIDTH-1:0]               cfg_data_i
);
  import sast_pkg::*;

  localparam logic [COORD_WIDTH-1:0] MinRst = COORD_WIDTH'(BoxMinReset);
  localparam logic [COORD_WIDTH-1:0] MaxRst = COORD_WIDTH'(BoxMaxReset);

  logic [COORD_WIDTH-1:0] box_q [NumRegs];
  logic                   adv;
  logic                   v1_q, v2_q, v3_q;
  logic                   hit;

  logic signed [COORD_WIDTH:0] d    [NumAxes];
  logic signed [COORD_WIDTH:0] ent  [NumAxes];
  logic signed [COORD_WIDTH:0] ext  [NumAxes];
  axis_flags_t                 flags[NumAxes];

  // Box registers; always ready, out-of-range indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        box_q[i] <= (i % 2 == 0) ? MinRst : MaxRst;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_X: box_q[0] <= cfg_data_i;
        REG_MAX_X: box_q[1] <= cfg_data_i;
        REG_MIN_Y: box_q[2] <= cfg_data_i;
        REG_MAX_Y: box_q[3] <= cfg_data_i;
        REG_MIN_Z: box_q[4] <= cfg_data_i;
        REG_MAX_Z: box_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance all stages together unless the result register is full and stalled.
  assign adv           = !v3_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: per-axis differences.
  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    sast_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis (
      .clk_i   (clk_i),
      .en_i    (adv),
      .s_i     (s_axis_tdata[a*COORD_WIDTH +: COORD_WIDTH]),
      .e_i     (s_axis_tdata[(a+NumAxes)*COORD_WIDTH +: COORD_WIDTH]),
      .bmin_i  (box_q[2*a]),
      .bmax_i  (box_q[2*a+1]),
      .d_o     (d[a]),
      .ent_o   (ent[a]),
      .ext_o   (ext[a]),
      .flags_o (flags[a])
    );
  end

  // Stages 2 and 3: cross products, then compare and reduce into the result register.
  sast_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk_i   (clk_i),
    .en_i    (adv),
    .d_i     (d),
    .ent_i   (ent),
    .ext_i   (ext),
    .flags_i (flags),
    .hit_o   (hit)
  );

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {7'd0, hit};

  `SAST_ASSERT(a_stage_adv, (v2_q && adv) |=> v3_q, "stage 2 item lost on advance")
  `SAST_ASSERT(a_stall_hold, !adv |=> ($stable(v1_q) && $stable(v2_q)), "pipeline moved in stall")
  `SAST_ASSERT(a_cfg_drop, (cfg_valid_i && cfg_index_i > REG_MAX_Z) |=> $stable(box_q[0]), "bad index")

endmodule

`default_nettype wire

>>> test/segment_aabb_slab_test_core_test.sv
// Testbench for the segment/box slab test core: directed and random segments
// against several box settings, with a scoreboard that predicts the hit flag.
// Depends on sast_pkg and segment_aabb_slab_test_core.
`timescale 1ns / 1ps

class hit_scoreboard;
  bit hit_q[$];
  int errors;

  function void note_segment(bit hit);
    hit_q.push_back(hit);
  endfunction

  function void check_result(logic [7:0] tdata);
    bit want;
    if (hit_q.size() == 0) begin
      $error("result without pending segment: hit actual %0d", tdata[0]);
      errors++;
      return;
    end
    want = hit_q.pop_front();
    if (tdata[0] !== want) begin
      $error("hit mismatch: expected %0d actual %0d", want, tdata[0]);
      errors++;
    end
    if (tdata[7:1] !== 7'd0) begin
      $error("fill mismatch: expected 0 actual %0d", tdata[7:1]);
      errors++;
    end
  endfunction
endclass

module segment_aabb_slab_test_core_test;
  import sast_pkg::*;

  localparam int CW = 16;
  localparam int DW = ((6*CW+7)/8)*8;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  // Local copy of the box: index order min_x, max_x, min_y, max_y, min_z, max_z.
  logic signed [CW-1:0] box_reg [NumRegs];
  hit_scoreboard sb = new();
  bit long_hold = 1'b0;
  int idle_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  segment_aabb_slab_test_core #(.COORD_WIDTH(CW)) uut (.*);

  // Sign of an/ad - bn/bd with positive denominators; operands fit easily in 64 bits.
  function automatic int frac_sign(longint an, longint ad, longint bn, longint bd);
    longint p, q;
    p = an * bd;
    q = bn * ad;
    return (p > q) ? 1 : (p < q) ? -1 : 0;
  endfunction

  function automatic bit slab_hit(logic [DW-1:0] seg);
    longint lo_n, lo_d, hi_n, hi_d, s, e, bmin, bmax, d, en, ex;
    lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
    for (int a = 0; a < 3; a++) begin
      s = longint'($signed(seg[a*CW +: CW]));
      e = longint'($signed(seg[(a+3)*CW +: CW]));
      bmin = longint'(box_reg[2*a]);
      bmax = longint'(box_reg[2*a+1]);
      if (e == s) begin
        if (s < bmin || s > bmax) return 1'b0;
        continue;
      end
      if (e > s) begin
        d = e - s; en = bmin - s; ex = bmax - s;
      end else begin
        d = s - e; en = s - bmax; ex = s - bmin;
      end
      if (frac_sign(en, d, lo_n, lo_d) > 0) begin
        lo_n = en; lo_d = d;
      end
      if (frac_sign(ex, d, hi_n, hi_d) < 0) begin
        hi_n = ex; hi_d = d;
      end
      if (frac_sign(lo_n, lo_d, hi_n, hi_d) > 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One register write; the config channel is then left idle before the task returns.
  task automatic write_box(logic [CfgIdxWidth-1:0] idx, logic [CW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NumRegs) box_reg[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic set_box(int x0, int x1, int y0, int y1, int z0, int z1);
    write_box(REG_MIN_X, x0[CW-1:0]);
    write_box(REG_MAX_X, x1[CW-1:0]);
    write_box(REG_MIN_Y, y0[CW-1:0]);
    write_box(REG_MAX_Y, y1[CW-1:0]);
    write_box(REG_MIN_Z, z0[CW-1:0]);
    write_box(REG_MAX_Z, z1[CW-1:0]);
  endtask

  // Offer one segment, after a random gap if gap is set; hold valid until the transfer.
  // Valid drops only for a gap; wait_drain drops it after the last segment.
  task automatic send_segment(logic [DW-1:0] seg, bit gap);
    int n;
    n = gap ? $urandom_range(0, 14) : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= seg;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_segment(slab_hit(seg));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.hit_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] pack_seg(int sx, int sy, int sz, int ex, int ey, int ez);
    return {ez[CW-1:0], ey[CW-1:0], ex[CW-1:0], sz[CW-1:0], sy[CW-1:0], sx[CW-1:0]};
  endfunction

  // Random coordinate: mostly near the box scale, sometimes full range.
  function automatic int rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return ($urandom_range(0, 1) ? 32767 : -32768);
      default: return $urandom_range(0, 2048) - 1024;
    endcase
  endfunction

  task automatic random_phase(int count);
    bit burst;
    for (int i = 0; i < count; i++) begin
      burst = (i % 50) < 10;
      send_segment(pack_seg(rnd_coord(), rnd_coord(), rnd_coord(),
                            rnd_coord(), rnd_coord(), rnd_coord()), !burst);
    end
  endtask

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin : p_recv
    int n;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        long_hold = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      m_axis_tready <= ($urandom_range(0, 1) == 1);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog on cycles with no transfer anywhere.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o) || long_hold)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > WatchdogLimit) begin
      $display("segment_aabb_slab_test_core test failed");
      $finish;
    end
  end

  initial begin
    box_reg[0] = CW'(BoxMinReset); box_reg[1] = CW'(BoxMaxReset);
    box_reg[2] = CW'(BoxMinReset); box_reg[3] = CW'(BoxMaxReset);
    box_reg[4] = CW'(BoxMinReset); box_reg[5] = CW'(BoxMaxReset);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset box is empty: a point at the origin must miss.
    send_segment(pack_seg(0, 0, 0, 0, 0, 0), 1'b1);
    send_segment(pack_seg(-32768, -32768, -32768, 32767, 32767, 32767), 1'b1);
    wait_drain();

    // Unit-ish box [-256, 256] on every axis.
    set_box(-256, 256, -256, 256, -256, 256);
    send_segment(pack_seg(0, 0, 0, 0, 0, 0), 1'b1);            // point inside
    send_segment(pack_seg(256, 256, 256, 256, 256, 256), 1'b1); // point on corner
    send_segment(pack_seg(257, 0, 0, 257, 0, 0), 1'b1);         // point just outside
    send_segment(pack_seg(-512, 0, 0, 512, 0, 0), 1'b1);        // crossing along x
    send_segment(pack_seg(512, 0, 0, -512, 0, 0), 1'b1);        // reversed direction
    send_segment(pack_seg(-512, 256, 0, 512, 256, 0), 1'b1);    // grazing a face
    send_segment(pack_seg(-512, -512, 0, 512, 512, 0), 1'b1);   // diagonal through edge
    send_segment(pack_seg(-512, 0, 0, 0, 1024, 0), 1'b1);       // passes outside, near a corner
    send_segment(pack_seg(-512, 0, 0, -300, 0, 0), 1'b1);       // stops short
    send_segment(pack_seg(300, 300, 0, 600, 600, 0), 1'b1);     // pointing away
    send_segment(pack_seg(-32768, -32768, -32768, 32767, 32767, 32767), 1'b1);
    send_segment(pack_seg(32767, -32768, 32767, -32768, 32767, -32768), 1'b1);
    wait_drain();

    // Inverted on one axis only.
    set_box(-256, 256, 300, -300, -256, 256);
    send_segment(pack_seg(0, 0, 0, 0, 0, 0), 1'b1);
    send_segment(pack_seg(-512, -512, -512, 512, 512, 512), 1'b1);
    wait_drain();
    // Out-of-range index must be ignored.
    write_box(3'd6, 16'h0000);
    write_box(3'd7, 16'hFFFF);

    // Full-range box, then random content.
    set_box(-32768, 32767, -32768, 32767, -32768, 32767);
    random_phase(60);
    wait_drain();

    set_box(-400, 700, -100, 900, -1000, 50);
    // Long receiver hold-off while the sender keeps offering.
    long_hold = 1'b1;
    random_phase(120);
    wait_drain();

    set_box(0, 0, 0, 0, 0, 0);
    random_phase(40);
    wait_drain();

    set_box(32767, 32767, -32768, -32768, -1024, 1024);
    random_phase(40);
    wait_drain();

    set_box($urandom_range(0, 1024) - 1024, $urandom_range(0, 1024),
            $urandom_range(0, 1024) - 1024, $urandom_range(0, 1024),
            $urandom_range(0, 1024) - 1024, $urandom_range(0, 1024));
    random_phase(140);
    wait_drain();

    if (sb.errors == 0)
      $display("segment_aabb_slab_test_core test passed");
    else
      $display("segment_aabb_slab_test_core test failed");
    $finish;
  end
endmodule
